FILE: rtl/core/wsmac_pkg.sv
package wsmac_pkg;

  // Default width of byte counts and lengths
  localparam int LengthBitsDefault = 24;
  // Limit after reset, truncated to the configured length width
  localparam int MaxBytesReset = 65536;

  localparam logic OpFeed  = 1'b0;
  localparam logic OpReset = 1'b1;

  localparam logic [2:0] KindText   = 3'd0;
  localparam logic [2:0] KindBinary = 3'd1;
  localparam logic [2:0] KindPing   = 3'd2;
  localparam logic [2:0] KindPong   = 3'd3;
  localparam logic [2:0] KindClose  = 3'd4;

  localparam logic [1:0] FailNone     = 2'd0;
  localparam logic [1:0] FailProtocol = 2'd1;
  localparam logic [1:0] FailTooLarge = 2'd2;

  // Control part of one chunk descriptor
  typedef struct packed {
    logic       opcode;
    logic [2:0] kind;
    logic       frame_done;
    logic       more_frames;
  } chunk_ctl_t;

  function automatic logic is_control_kind(input logic [2:0] kind);
    return (kind == KindPing) || (kind == KindPong) || (kind == KindClose);
  endfunction

endpackage

FILE: rtl/core/wsmac_in_reg.sv
module wsmac_in_reg
  import wsmac_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  chunk_ctl_t             in_ctl,
  input  logic [LENGTH_BITS-1:0] in_length,
  output logic                   item_valid,
  input  logic                   item_take,
  output chunk_ctl_t             item_ctl,
  output logic [LENGTH_BITS-1:0] item_length
);

  logic load;

  assign in_stall = item_valid && !item_take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_ctl    <= in_ctl;
      item_length <= in_length;
    end
  end

endmodule

FILE: rtl/core/wsmac_engine.sv
module wsmac_engine
  import wsmac_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [LENGTH_BITS-1:0] max_bytes,
  input  logic                   item_valid,
  output logic                   item_take,
  input  chunk_ctl_t             item_ctl,
  input  logic [LENGTH_BITS-1:0] item_length,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   message_ready,
  output logic [2:0]             message_kind,
  output logic [LENGTH_BITS-1:0] message_length,
  output logic [1:0]             failure_code,
  output logic                   is_terminal
);

  logic [LENGTH_BITS-1:0] data_count, data_count_next;
  logic                   data_kind_valid, data_kind_valid_next;
  logic [2:0]             data_kind, data_kind_next;
  logic [LENGTH_BITS-1:0] ctrl_count, ctrl_count_next;
  logic                   ctrl_kind_valid, ctrl_kind_valid_next;
  logic [2:0]             ctrl_kind, ctrl_kind_next;
  logic                   stream_closed, stream_closed_next;

  logic                   res_ready;
  logic [2:0]             res_kind;
  logic [LENGTH_BITS-1:0] res_length;
  logic [1:0]             res_fail;
  logic                   res_term;

  logic                   control;
  logic                   sel_valid;
  logic [2:0]             sel_kind;
  logic [LENGTH_BITS-1:0] sel_count;
  logic [LENGTH_BITS-1:0] new_count;
  logic                   mismatch;
  logic                   overflow;
  logic                   partial;

  assign item_take = item_valid && (!out_valid || !out_stall);

  assign control   = is_control_kind(item_ctl.kind);
  assign sel_valid = control ? ctrl_kind_valid : data_kind_valid;
  assign sel_kind  = control ? ctrl_kind : data_kind;
  assign sel_count = control ? ctrl_count : data_count;
  assign new_count = sel_count + item_length;
  assign mismatch  = (sel_valid && (sel_kind != item_ctl.kind))
                   || (control && item_ctl.more_frames);
  assign overflow  = (item_length > max_bytes) || (sel_count > (max_bytes - item_length));
  assign partial   = !item_ctl.frame_done || (!control && item_ctl.more_frames);

  always_comb begin
    data_count_next      = data_count;
    data_kind_valid_next = data_kind_valid;
    data_kind_next       = data_kind;
    ctrl_count_next      = ctrl_count;
    ctrl_kind_valid_next = ctrl_kind_valid;
    ctrl_kind_next       = ctrl_kind;
    stream_closed_next   = stream_closed;
    res_ready            = 1'b0;
    res_kind             = KindText;
    res_length           = '0;
    res_fail             = FailNone;
    res_term             = 1'b0;

    if (item_ctl.opcode == OpReset) begin
      data_count_next      = '0;
      data_kind_valid_next = 1'b0;
      data_kind_next       = KindText;
      ctrl_count_next      = '0;
      ctrl_kind_valid_next = 1'b0;
      ctrl_kind_next       = KindText;
      stream_closed_next   = 1'b0;
    end else if (stream_closed || (max_bytes == '0)) begin
      res_fail = FailProtocol;
      res_term = 1'b1;
    end else if (mismatch || overflow) begin
      data_count_next      = '0;
      data_kind_valid_next = 1'b0;
      data_kind_next       = KindText;
      ctrl_count_next      = '0;
      ctrl_kind_valid_next = 1'b0;
      ctrl_kind_next       = KindText;
      stream_closed_next   = 1'b1;
      res_fail             = mismatch ? FailProtocol : FailTooLarge;
      res_term             = 1'b1;
    end else if (partial) begin
      if (control) begin
        ctrl_count_next      = new_count;
        ctrl_kind_valid_next = 1'b1;
        ctrl_kind_next       = item_ctl.kind;
      end else begin
        data_count_next      = new_count;
        data_kind_valid_next = 1'b1;
        data_kind_next       = item_ctl.kind;
      end
    end else begin
      if (control) begin
        ctrl_count_next      = '0;
        ctrl_kind_valid_next = 1'b0;
        ctrl_kind_next       = KindText;
      end else begin
        data_count_next      = '0;
        data_kind_valid_next = 1'b0;
        data_kind_next       = KindText;
      end
      res_ready  = 1'b1;
      res_kind   = item_ctl.kind;
      res_length = new_count;
      if (item_ctl.kind == KindClose) begin
        stream_closed_next = 1'b1;
        res_term           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_count      <= '0;
      data_kind_valid <= 1'b0;
      data_kind       <= KindText;
      ctrl_count      <= '0;
      ctrl_kind_valid <= 1'b0;
      ctrl_kind       <= KindText;
      stream_closed   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (item_take) begin
        data_count      <= data_count_next;
        data_kind_valid <= data_kind_valid_next;
        data_kind       <= data_kind_next;
        ctrl_count      <= ctrl_count_next;
        ctrl_kind_valid <= ctrl_kind_valid_next;
        ctrl_kind       <= ctrl_kind_next;
        stream_closed   <= stream_closed_next;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      message_ready  <= res_ready;
      message_kind   <= res_kind;
      message_length <= res_length;
      failure_code   <= res_fail;
      is_terminal    <= res_term;
    end
  end

  // reset beat leaves nothing pending
  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    item_take && (item_ctl.opcode == OpReset)
    |=> !stream_closed && !data_kind_valid && !ctrl_kind_valid)
    else $error("reset beat left pending state");

  // a latched stream rejects every feed
  a_closed_rejects: assert property (@(posedge clk) disable iff (rst)
    item_take && stream_closed && (item_ctl.opcode == OpFeed)
    |=> out_valid && (failure_code == FailProtocol) && is_terminal && !message_ready)
    else $error("feed on closed stream not rejected");

  // a completed message never carries a failure
  a_ready_no_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_ready |-> (failure_code == FailNone))
    else $error("completed message with failure");

  // every failure is terminal
  a_fail_terminal: assert property (@(posedge clk) disable iff (rst)
    out_valid && (failure_code != FailNone) |-> is_terminal)
    else $error("failure without terminal flag");

endmodule

FILE: rtl/core/websocket_message_assembly_checker_core.sv
// Channel   Direction  Handshake            Beat content
// in        input      in_valid / in_stall  opcode, chunk_kind, chunk_length, flags
// out       output     out_valid / out_stall message_ready/kind/length, failure, terminal
// cfg       input      cfg_valid / cfg_ready max_message_bytes write data
//
// One chunk descriptor per cycle unless out_stall holds the path; each beat
// yields exactly one result beat. An accepted beat sits in the input register
// until taken, then is checked into the result register, which raises out_valid.
// Pending counts and kinds update as the beat leaves the input register, so
// back-to-back beats see each other's state with no bubble.
// out_stall holds the result register and, through it, the input register.
// rst is synchronous: pending state cleared, limit back to 65536 (truncated).
module websocket_message_assembly_checker_core
  import wsmac_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LENGTH_BITS-1:0] cfg_data,
  // chunk descriptors
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  logic [2:0]             chunk_kind,
  input  logic [LENGTH_BITS-1:0] chunk_length,
  input  logic                   frame_done,
  input  logic                   more_frames,
  // results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   message_ready,
  output logic [2:0]             message_kind,
  output logic [LENGTH_BITS-1:0] message_length,
  output logic [1:0]             failure_code,
  output logic                   is_terminal
);

  localparam logic [LENGTH_BITS-1:0] MaxReset = LENGTH_BITS'(MaxBytesReset);

  logic [LENGTH_BITS-1:0] max_bytes;
  chunk_ctl_t             in_ctl;
  chunk_ctl_t             item_ctl;
  logic [LENGTH_BITS-1:0] item_length;
  logic                   item_valid;
  logic                   item_take;

  // Limit register: writes always taken; user must write only while idle, not enforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MaxReset;
    end else if (cfg_valid && cfg_ready) begin
      max_bytes <= cfg_data;
    end
  end

  assign in_ctl.opcode      = opcode;
  assign in_ctl.kind        = chunk_kind;
  assign in_ctl.frame_done  = frame_done;
  assign in_ctl.more_frames = more_frames;

  // Input register stage
  wsmac_in_reg #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ctl     (in_ctl),
    .in_length  (chunk_length),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item_ctl   (item_ctl),
    .item_length(item_length)
  );

  // Checks, pending state and result register
  wsmac_engine #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .max_bytes     (max_bytes),
    .item_valid    (item_valid),
    .item_take     (item_take),
    .item_ctl      (item_ctl),
    .item_length   (item_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .message_ready (message_ready),
    .message_kind  (message_kind),
    .message_length(message_length),
    .failure_code  (failure_code),
    .is_terminal   (is_terminal)
  );

endmodule

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsmac_pkg::*;

  localparam int LB = LengthBitsDefault;
  // Kinds past close carry no name in the protocol; the block treats them as data.
  localparam logic [2:0] KindSpareLo = 3'd5;
  localparam logic [2:0] KindSpareHi = 3'd7;
  localparam logic [LB-1:0] LenAllOnes = '1;

  // One result beat as seen on the out channel.
  typedef struct {
    logic          ready;
    logic [2:0]    kind;
    logic [LB-1:0] length;
    logic [1:0]    fail;
    logic          term;
  } msg_result_t;

  // Tracks pending data/control byte counts and the terminal latch, and keeps
  // the queue of result beats still owed by the block.
  class assembly_scoreboard;
    logic [LB-1:0] limit;
    logic [LB-1:0] data_bytes, ctrl_bytes;
    logic          data_open, ctrl_open;
    logic [2:0]    data_kind, ctrl_kind;
    logic          closed;
    msg_result_t   due_messages[$];
    int            errors;

    function new();
      limit  = LB'(MaxBytesReset);
      errors = 0;
      drop_pending();
    endfunction

    function void drop_pending();
      data_bytes = '0;
      data_open  = 1'b0;
      data_kind  = KindText;
      ctrl_bytes = '0;
      ctrl_open  = 1'b0;
      ctrl_kind  = KindText;
      closed     = 1'b0;
    endfunction

    function int pending();
      return due_messages.size();
    endfunction

    // Called for every accepted input beat; works out the result it causes.
    function void take_chunk(logic op, logic [2:0] k, logic [LB-1:0] len,
                             logic done, logic more);
      msg_result_t   r;
      logic          ctl;
      logic [LB-1:0] cnt;
      logic          open;
      logic [2:0]    pk;
      r = '{ready: 1'b0, kind: KindText, length: '0, fail: FailNone, term: 1'b0};
      if (op == OpReset) begin
        drop_pending();
      end else if (closed || limit == '0) begin
        // terminal or zero limit: reject, nothing latches
        r.fail = FailProtocol;
        r.term = 1'b1;
      end else begin
        ctl  = (k == KindPing) || (k == KindPong) || (k == KindClose);
        cnt  = ctl ? ctrl_bytes : data_bytes;
        open = ctl ? ctrl_open : data_open;
        pk   = ctl ? ctrl_kind : data_kind;
        if ((open && pk != k) || (ctl && more)) begin
          drop_pending();
          closed = 1'b1;
          r.fail = FailProtocol;
          r.term = 1'b1;
        end else if (len > limit || cnt > limit - len) begin
          drop_pending();
          closed = 1'b1;
          r.fail = FailTooLarge;
          r.term = 1'b1;
        end else begin
          cnt = cnt + len;
          if (!done || (!ctl && more)) begin
            open = 1'b1;
            pk   = k;
          end else begin
            r.ready  = 1'b1;
            r.kind   = k;
            r.length = cnt;
            cnt      = '0;
            open     = 1'b0;
            pk       = KindText;
            if (k == KindClose) begin
              closed = 1'b1;
              r.term = 1'b1;
            end
          end
          if (ctl) begin
            ctrl_bytes = cnt;
            ctrl_open  = open;
            ctrl_kind  = pk;
          end else begin
            data_bytes = cnt;
            data_open  = open;
            data_kind  = pk;
          end
        end
      end
      due_messages.push_back(r);
    endfunction

    function void diff_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Called for every accepted result beat.
    function void match_result(msg_result_t got);
      msg_result_t want;
      if (due_messages.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
        return;
      end
      want = due_messages.pop_front();
      diff_field("message_ready", want.ready, got.ready);
      diff_field("message_kind", want.kind, got.kind);
      diff_field("message_length", want.length, got.length);
      diff_field("failure_code", want.fail, got.fail);
      diff_field("is_terminal", want.term, got.term);
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [LB-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          opcode = OpFeed;
  logic [2:0]    chunk_kind = KindText;
  logic [LB-1:0] chunk_length = '0;
  logic          frame_done = 1'b0;
  logic          more_frames = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          message_ready;
  logic [2:0]    message_kind;
  logic [LB-1:0] message_length;
  logic [1:0]    failure_code;
  logic          is_terminal;

  assembly_scoreboard sb = new();

  int burst_left = 0;   // beats left in the current sender burst
  int beats_sent = 0;   // accepted input beats so far

  websocket_message_assembly_checker_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .chunk_kind     (chunk_kind),
    .chunk_length   (chunk_length),
    .frame_done     (frame_done),
    .more_frames    (more_frames),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .message_ready  (message_ready),
    .message_kind   (message_kind),
    .message_length (message_length),
    .failure_code   (failure_code),
    .is_terminal    (is_terminal)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result monitor. Values read right after the edge are the pre-edge ones,
  // so this sees exactly what the block saw on the handshake.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.match_result(msg_result_t'{message_ready, message_kind, message_length,
                                    failure_code, is_terminal});
  end

  // Receiver back-pressure. Modes switch at random intervals: free flowing,
  // light stall, heavy stall, coin flip. Now and then (and once for sure early
  // in the random part) it holds off for a long stretch so the block fills up
  // and has to stall its input while the sender keeps offering beats.
  initial begin
    int cyc;
    int mode;
    int mode_left;
    int hold_left;
    cyc       = 0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 600)
        hold_left = 64;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
          if ($urandom_range(0, 15) == 0)
            hold_left = $urandom_range(40, 80);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Offer one beat and hold it until accepted. The sender runs in bursts:
  // when a burst runs out, valid drops for a random gap (often none at all).
  task automatic send_beat(input logic op, input logic [2:0] k, input logic [LB-1:0] len,
                           input logic done, input logic more);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid     <= 1'b1;
    opcode       <= op;
    chunk_kind   <= k;
    chunk_length <= len;
    frame_done   <= done;
    more_frames  <= more;
    do @(posedge clk); while (in_stall);
    sb.take_chunk(op, k, len, done, more);
    beats_sent++;
  endtask

  // Sender pause: nothing offered until every owed result has come back.
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_limit(input logic [LB-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.limit = value;
    cfg_valid <= 1'b0;
  endtask

  // Chunk length skewed around the current limit: mostly small, some near or
  // at the limit, a few just over it, a few fully random.
  function automatic logic [LB-1:0] pick_len(input logic [LB-1:0] lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return LB'($urandom_range(0, (lim < 40) ? lim : 40));
    if (r < 70) return LB'($urandom_range(0, lim / 4));
    if (r < 82) return LB'($urandom_range(0, lim));
    if (r < 88) return lim;
    if (r < 92) return '0;
    if (r < 95) return lim + 1'b1;
    return LB'($urandom);
  endfunction

  task automatic reset_beat();
    send_beat(OpReset, 3'($urandom_range(0, 7)), LB'($urandom), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // Single-frame control message, possibly split into several chunks.
  task automatic ctrl_message();
    logic [2:0] k;
    int chunks;
    if ($urandom_range(0, 9) == 0)
      k = KindClose;
    else
      k = $urandom_range(0, 1) ? KindPing : KindPong;
    chunks = $urandom_range(1, 3);
    for (int c = 0; c < chunks; c++)
      send_beat(OpFeed, k, pick_len(sb.limit), c == chunks - 1, 1'b0);
  endtask

  // Fragmented data message; control messages may cut in between chunks.
  task automatic data_message();
    logic [2:0] k;
    int frags;
    int chunks;
    if ($urandom_range(0, 9) == 0)
      k = 3'($urandom_range(KindSpareLo, KindSpareHi));
    else
      k = 3'($urandom_range(KindText, KindBinary));
    frags = $urandom_range(1, 4);
    for (int f = 0; f < frags; f++) begin
      chunks = $urandom_range(1, 3);
      for (int c = 0; c < chunks; c++) begin
        if ($urandom_range(0, 4) == 0)
          ctrl_message();
        send_beat(OpFeed, k, pick_len(sb.limit), c == chunks - 1, f != frags - 1);
      end
    end
  endtask

  task automatic noise_beat();
    send_beat(($urandom_range(0, 9) == 0) ? OpReset : OpFeed, 3'($urandom_range(0, 7)),
              $urandom_range(0, 1) ? LB'($urandom) : pick_len(sb.limit),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Deliberately malformed sequences.
  task automatic broken_sequence();
    case ($urandom_range(0, 3))
      0: send_beat(OpFeed, $urandom_range(0, 1) ? KindPing : KindClose, pick_len(sb.limit),
                   1'($urandom_range(0, 1)), 1'b1);
      1: begin
        send_beat(OpFeed, KindText, pick_len(sb.limit), 1'b1, 1'b1);
        send_beat(OpFeed, KindBinary, pick_len(sb.limit), 1'b1, 1'b0);
      end
      2: begin
        send_beat(OpFeed, KindPing, pick_len(sb.limit), 1'b0, 1'b0);
        send_beat(OpFeed, KindPong, pick_len(sb.limit), 1'b1, 1'b0);
      end
      default: begin
        send_beat(OpFeed, KindBinary, sb.limit, 1'b0, 1'b1);
        send_beat(OpFeed, KindBinary, LB'($urandom_range(1, 100)), 1'b1, 1'b0);
      end
    endcase
  endtask

  task automatic random_phase(input int n);
    int stop;
    int unsigned pick;
    stop = beats_sent + n;
    while (beats_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (sb.closed && pick < 85) reset_beat();   // get out of the terminal state
      else if (pick < 55) data_message();
      else if (pick < 72) ctrl_message();
      else if (pick < 86) noise_beat();
      else if (pick < 96) broken_sequence();
      else reset_beat();
    end
  endtask

  // Directed part, first at the reset limit of 65536.
  task automatic directed_part();
    // fragmented text with a ping cutting in, then a zero-byte final frame
    send_beat(OpFeed, KindText, 24'd10, 1'b0, 1'b1);
    send_beat(OpFeed, KindText, 24'd20, 1'b1, 1'b1);
    send_beat(OpFeed, KindPing, 24'd5, 1'b1, 1'b0);
    send_beat(OpFeed, KindText, 24'd0, 1'b1, 1'b0);
    // exactly at the limit, and a spare kind taken as data
    send_beat(OpFeed, KindBinary, 24'd65536, 1'b1, 1'b0);
    send_beat(OpFeed, KindSpareLo, 24'd3, 1'b1, 1'b0);
    // control frame in two chunks
    send_beat(OpFeed, KindPong, 24'd7, 1'b0, 1'b0);
    send_beat(OpFeed, KindPong, 24'd1, 1'b1, 1'b0);
    // kind mismatch latches terminal; next feed bounces
    send_beat(OpFeed, KindBinary, 24'd1, 1'b1, 1'b1);
    send_beat(OpFeed, KindText, 24'd1, 1'b1, 1'b0);
    send_beat(OpFeed, KindText, 24'd1, 1'b1, 1'b0);
    send_beat(OpReset, KindText, '0, 1'b0, 1'b0);
    // fragmented control frame
    send_beat(OpFeed, KindPing, 24'd2, 1'b1, 1'b1);
    send_beat(OpReset, KindSpareHi, LenAllOnes, 1'b1, 1'b1);
    // too large in one chunk, then by accumulation
    send_beat(OpFeed, KindText, 24'd65537, 1'b1, 1'b0);
    send_beat(OpReset, KindText, '0, 1'b0, 1'b0);
    send_beat(OpFeed, KindBinary, 24'd65000, 1'b1, 1'b1);
    send_beat(OpFeed, KindBinary, 24'd537, 1'b1, 1'b0);
    send_beat(OpReset, KindText, '0, 1'b0, 1'b0);
    // completed close is terminal
    send_beat(OpFeed, KindClose, 24'd2, 1'b1, 1'b0);
    send_beat(OpFeed, KindPing, 24'd1, 1'b1, 1'b0);
    send_beat(OpReset, KindText, '0, 1'b0, 1'b0);
    // zero limit rejects without latching
    drain_results();
    write_limit('0);
    send_beat(OpFeed, KindText, 24'd1, 1'b1, 1'b0);
    send_beat(OpFeed, KindPing, 24'd0, 1'b1, 1'b0);
    // largest limit: a message of exactly all-ones bytes
    drain_results();
    write_limit(LenAllOnes);
    send_beat(OpFeed, KindSpareHi, LenAllOnes, 1'b1, 1'b1);
    send_beat(OpFeed, KindSpareHi, '0, 1'b1, 1'b0);
  endtask

  initial begin
    logic [LB-1:0] lim;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    directed_part();
    // random phases, each under its own limit; block drained before each write
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: lim = 24'd1;
        1: lim = 24'd200;
        2: lim = '0;
        3: lim = 24'd65536;
        4: lim = LenAllOnes;
        5: lim = LB'($urandom_range(2, 20000));
        default: lim = 24'd3000;
      endcase
      drain_results();
      write_limit(lim);
      random_phase((p == 2) ? 60 : 320);
    end
    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
